// ===== hw/rtl/fed_pkg.sv =====
`default_nettype none
package fed_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DVD_W     = 32 + FRAC_BITS;

    localparam logic signed [67:0] ONE68  = 68'sd1 <<< FRAC_BITS;
    localparam logic signed [32:0] ONE33  = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] HALF66 = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [67:0] MAX68  = 68'sd2147483647;
    localparam logic signed [67:0] MIN68  = -68'sd2147483648;
    localparam logic [DVD_W-1:0]   QPOS_LIM = DVD_W'(32'h7fffffff);
    localparam logic [DVD_W-1:0]   QNEG_LIM = DVD_W'(32'h80000000);

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m22;
        logic signed [31:0] in_x1;
        logic signed [31:0] in_x2;
        logic signed [31:0] out_x1;
        logic signed [31:0] out_x2;
    } t_in;

    typedef struct packed {
        logic signed [31:0] delta_d;
        logic signed [31:0] lev_in;
        logic signed [31:0] lev_out;
        logic signed [31:0] cross_form;
        logic signed [31:0] delta_a;
        logic               div_zero;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic signed [31:0] dd;
        logic signed [31:0] dii;
        logic signed [31:0] doo;
        logic signed [31:0] dio;
        logic               dz;
        logic               sat;
        logic               qneg;
    } t_carry;

    function automatic logic signed [65:0] mul33(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        mul33 = a * b;
    endfunction

    function automatic logic signed [67:0] qrnd(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = (p + HALF66) >>> FRAC_BITS;
        qrnd = {{2{s[65]}}, s};
    endfunction

    function automatic logic signed [32:0] ext33(input logic signed [31:0] a);
        ext33 = {a[31], a};
    endfunction

    function automatic logic signed [67:0] ext68(input logic signed [31:0] a);
        ext68 = {{36{a[31]}}, a};
    endfunction

    // Returns {clipped flag, value}.
    function automatic logic [32:0] sat32(input logic signed [67:0] x);
        if (x > MAX68) begin
            sat32 = {1'b1, 32'h7fffffff};
        end else if (x < MIN68) begin
            sat32 = {1'b1, 32'h80000000};
        end else begin
            sat32 = {1'b0, x[31:0]};
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fedorov_exchange_delta_core.sv =====
`default_nettype none
// Fedorov exchange delta kernel: takes one beat per cycle unless the output
// stalls, and returns the D and A criterion deltas with the quadratic forms,
// in signed Q16.16. The pipeline holds the six multiply and sum stages,
// one operand stage and the radix-2 divider, which spends one pipeline stage
// per quotient bit. Throughput is one beat per cycle; a stall at the output
// freezes the whole pipeline. delta_a is zero when the divisor is zero.
module fedorov_exchange_delta_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fed_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fed_pkg::t_out      o_out_data
);
    import fed_pkg::*;

    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic [7:1] r_vld;

    // Stage 1: products for M*rin and M*rout.
    logic signed [31:0] mk1 [3];
    logic signed [31:0] mk2 [3];
    logic signed [65:0] r1_pv [6];
    logic signed [65:0] r1_pw [6];
    logic signed [31:0] r1_m0 [3];
    logic signed [31:0] r1_ix1, r1_ix2, r1_ox1, r1_ox2;

    assign mk1[0] = i_in_data.m01;
    assign mk1[1] = i_in_data.m11;
    assign mk1[2] = i_in_data.m12;
    assign mk2[0] = i_in_data.m02;
    assign mk2[1] = i_in_data.m12;
    assign mk2[2] = i_in_data.m22;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_pv[2*k]   <= mul33(ext33(mk1[k]), ext33(i_in_data.in_x1));
                r1_pv[2*k+1] <= mul33(ext33(mk2[k]), ext33(i_in_data.in_x2));
                r1_pw[2*k]   <= mul33(ext33(mk1[k]), ext33(i_in_data.out_x1));
                r1_pw[2*k+1] <= mul33(ext33(mk2[k]), ext33(i_in_data.out_x2));
            end
            r1_m0[0] <= i_in_data.m00;
            r1_m0[1] <= i_in_data.m01;
            r1_m0[2] <= i_in_data.m02;
            r1_ix1   <= i_in_data.in_x1;
            r1_ix2   <= i_in_data.in_x2;
            r1_ox1   <= i_in_data.out_x1;
            r1_ox2   <= i_in_data.out_x2;
        end
    end

    // Stage 2: v and w, clipped.
    logic [32:0] n2_v [3];
    logic [32:0] n2_w [3];
    logic signed [31:0] r2_v [3];
    logic signed [31:0] r2_w [3];
    logic        r2_sat;
    logic signed [31:0] r2_ix1, r2_ix2, r2_ox1, r2_ox2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_v[k] = sat32(ext68(r1_m0[k]) + qrnd(r1_pv[2*k]) + qrnd(r1_pv[2*k+1]));
            n2_w[k] = sat32(ext68(r1_m0[k]) + qrnd(r1_pw[2*k]) + qrnd(r1_pw[2*k+1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_v[k] <= n2_v[k][31:0];
                r2_w[k] <= n2_w[k][31:0];
            end
            r2_sat <= n2_v[0][32] | n2_v[1][32] | n2_v[2][32]
                    | n2_w[0][32] | n2_w[1][32] | n2_w[2][32];
            r2_ix1 <= r1_ix1;
            r2_ix2 <= r1_ix2;
            r2_ox1 <= r1_ox1;
            r2_ox2 <= r1_ox2;
        end
    end

    // Stage 3: products for the quadratic and phi forms.
    logic signed [65:0] r3_p [15];
    logic signed [31:0] r3_v0, r3_w0;
    logic        r3_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p[0] <= mul33(ext33(r2_ix1), ext33(r2_v[1]));
            r3_p[1] <= mul33(ext33(r2_ix2), ext33(r2_v[2]));
            r3_p[2] <= mul33(ext33(r2_ox1), ext33(r2_w[1]));
            r3_p[3] <= mul33(ext33(r2_ox2), ext33(r2_w[2]));
            r3_p[4] <= mul33(ext33(r2_ix1), ext33(r2_w[1]));
            r3_p[5] <= mul33(ext33(r2_ix2), ext33(r2_w[2]));
            for (int k = 0; k < 3; k++) begin
                r3_p[6+k]  <= mul33(ext33(r2_v[k]), ext33(r2_v[k]));
                r3_p[9+k]  <= mul33(ext33(r2_w[k]), ext33(r2_w[k]));
                r3_p[12+k] <= mul33(ext33(r2_v[k]), ext33(r2_w[k]));
            end
            r3_v0  <= r2_v[0];
            r3_w0  <= r2_w[0];
            r3_sat <= r2_sat;
        end
    end

    // Stage 4: dii, doo, dio and the phi forms.
    logic [32:0] n4_dii, n4_doo, n4_dio, n4_pii, n4_poo, n4_pio;
    logic signed [31:0] r4_dii, r4_doo, r4_dio, r4_pii, r4_poo, r4_pio;
    logic        r4_sat;

    assign n4_dii = sat32(ext68(r3_v0) + qrnd(r3_p[0]) + qrnd(r3_p[1]));
    assign n4_doo = sat32(ext68(r3_w0) + qrnd(r3_p[2]) + qrnd(r3_p[3]));
    assign n4_dio = sat32(ext68(r3_w0) + qrnd(r3_p[4]) + qrnd(r3_p[5]));
    assign n4_pii = sat32(qrnd(r3_p[6]) + qrnd(r3_p[7]) + qrnd(r3_p[8]));
    assign n4_poo = sat32(qrnd(r3_p[9]) + qrnd(r3_p[10]) + qrnd(r3_p[11]));
    assign n4_pio = sat32(qrnd(r3_p[12]) + qrnd(r3_p[13]) + qrnd(r3_p[14]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dii <= n4_dii[31:0];
            r4_doo <= n4_doo[31:0];
            r4_dio <= n4_dio[31:0];
            r4_pii <= n4_pii[31:0];
            r4_poo <= n4_poo[31:0];
            r4_pio <= n4_pio[31:0];
            r4_sat <= r3_sat | n4_dii[32] | n4_doo[32] | n4_dio[32]
                    | n4_pii[32] | n4_poo[32] | n4_pio[32];
        end
    end

    // Stage 5: criterion products, with the one-plus and one-minus terms kept at 33 bits.
    logic signed [65:0] r5_e [5];
    logic signed [31:0] r5_dii, r5_doo, r5_dio;
    logic        r5_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_e[0] <= mul33(ONE33 + ext33(r4_dii), ONE33 - ext33(r4_doo));
            r5_e[1] <= mul33(ext33(r4_dio), ext33(r4_dio));
            r5_e[2] <= mul33(ONE33 - ext33(r4_dii), ext33(r4_poo));
            r5_e[3] <= mul33(ext33(r4_dio), ext33(r4_pio));
            r5_e[4] <= mul33(ONE33 + ext33(r4_doo), ext33(r4_pii));
            r5_dii  <= r4_dii;
            r5_doo  <= r4_doo;
            r5_dio  <= r4_dio;
            r5_sat  <= r4_sat;
        end
    end

    // Stage 6: D delta and A numerator.
    logic [32:0] n6_dd, n6_num;
    logic signed [67:0] n6_mid;
    t_carry r6_c;
    logic signed [31:0] r6_num;

    assign n6_mid = qrnd(r5_e[3]);
    assign n6_dd  = sat32(qrnd(r5_e[0]) + qrnd(r5_e[1]) - ONE68);
    assign n6_num = sat32(qrnd(r5_e[2]) + (n6_mid <<< 1) - qrnd(r5_e[4]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_c.dd   <= n6_dd[31:0];
            r6_c.dii  <= r5_dii;
            r6_c.doo  <= r5_doo;
            r6_c.dio  <= r5_dio;
            r6_c.dz   <= 1'b0;
            r6_c.qneg <= 1'b0;
            r6_c.sat  <= r5_sat | n6_dd[32] | n6_num[32];
            r6_num    <= n6_num[31:0];
        end
    end

    // Stage 7: divider operands as magnitudes, sign of quotient kept aside.
    logic signed [32:0] n7_den, n7_dneg, n7_num33, n7_nneg;
    logic [31:0] n7_dmag, n7_nmag;
    t_carry      n7_c;

    assign n7_den   = ONE33 + ext33(r6_c.dd);
    assign n7_dneg  = -n7_den;
    assign n7_num33 = ext33(r6_num);
    assign n7_nneg  = -n7_num33;
    assign n7_dmag  = n7_den[32] ? n7_dneg[31:0] : n7_den[31:0];
    assign n7_nmag  = r6_num[31] ? n7_nneg[31:0] : n7_num33[31:0];

    always_comb begin
        n7_c      = r6_c;
        n7_c.dz   = (n7_den == '0);
        n7_c.qneg = r6_num[31] ^ n7_den[32];
    end

    t_carry            r_c [DVD_W+1];
    logic [31:0]       r_a [DVD_W+1];
    logic [DVD_W-1:0]  r_q [DVD_W+1];
    logic [31:0]       r_d [DVD_W+1];
    logic [DVD_W-1:0]  r_dv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[0] <= n7_c;
            r_a[0] <= '0;
            r_q[0] <= {n7_nmag, {FRAC_BITS{1'b0}}};
            r_d[0] <= n7_dmag;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar g = 0; g < DVD_W; g++) begin : g_div
        logic [32:0] tmp;
        logic        ge;
        logic [32:0] diff;
        assign tmp  = {r_a[g], r_q[g][DVD_W-1]};
        assign ge   = (tmp >= {1'b0, r_d[g]});
        assign diff = tmp - {1'b0, r_d[g]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a[g+1] <= ge ? diff[31:0] : tmp[31:0];
                r_q[g+1] <= {r_q[g][DVD_W-2:0], ge};
                r_d[g+1] <= r_d[g];
                r_c[g+1] <= r_c[g];
            end
        end
    end

    // Output stage: sign, clip and zero-divisor handling.
    logic [DVD_W-1:0] qm;
    t_carry           fc;
    logic signed [31:0] n_da;
    logic             n_dsat;

    assign qm = r_q[DVD_W];
    assign fc = r_c[DVD_W];

    always_comb begin
        n_dsat = 1'b0;
        if (fc.dz) begin
            n_da = '0;
        end else if (fc.qneg) begin
            if (qm > QNEG_LIM) begin
                n_da   = 32'sh80000000;
                n_dsat = 1'b1;
            end else begin
                n_da = -qm[31:0];
            end
        end else if (qm > QPOS_LIM) begin
            n_da   = 32'sh7fffffff;
            n_dsat = 1'b1;
        end else begin
            n_da = qm[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_data.delta_d    <= fc.dd;
            o_out_data.lev_in     <= fc.dii;
            o_out_data.lev_out    <= fc.doo;
            o_out_data.cross_form <= fc.dio;
            o_out_data.delta_a    <= n_da;
            o_out_data.div_zero   <= fc.dz;
            o_out_data.saturated  <= fc.sat | n_dsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_dv        <= '0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[6:1], i_in_valid};
            r_dv        <= {r_dv[DVD_W-2:0], r_vld[7]};
            o_out_valid <= r_dv[DVD_W-1];
        end
    end

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_divzero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.div_zero) |-> (o_out_data.delta_a == '0))
        else $error("delta_a nonzero with zero divisor");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_dv))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ===== tb/sv/fed_delta_checker.sv =====
module fed_delta_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  fed_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  fed_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fed_pkg::t_in;
    import fed_pkg::t_out;

    localparam int QBITS = fed_pkg::FRAC_BITS;

    typedef logic signed [127:0] wide_t;

    t_out exp_deltas[$];
    int   fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = exp_deltas.size();

    function automatic wide_t clamp(input wide_t x, inout bit clipped);
        if (x > wide_t'(32'sh7fffffff)) begin
            clipped = 1'b1;
            return wide_t'(32'sh7fffffff);
        end
        if (x < wide_t'(-64'sd2147483648)) begin
            clipped = 1'b1;
            return wide_t'(-64'sd2147483648);
        end
        return x;
    endfunction

    // Fixed-point product rounded half up, which is a floor after adding half.
    function automatic wide_t qprod(input wide_t a, input wide_t b);
        wide_t half;
        half = wide_t'(1) <<< (QBITS - 1);
        return (a * b + half) >>> QBITS;
    endfunction

    function automatic t_out exchange_delta(input t_in x);
        wide_t one, m[3][3], rin[3], rout[3], v[3], w[3];
        wide_t dii, doo, dio, dd, pii, poo, pio, num, den, da;
        bit    clipped;
        t_out  r;
        clipped = 1'b0;
        one = wide_t'(1) <<< QBITS;
        m[0][0] = wide_t'(x.m00);
        m[0][1] = wide_t'(x.m01); m[1][0] = m[0][1];
        m[0][2] = wide_t'(x.m02); m[2][0] = m[0][2];
        m[1][1] = wide_t'(x.m11);
        m[1][2] = wide_t'(x.m12); m[2][1] = m[1][2];
        m[2][2] = wide_t'(x.m22);
        rin[0]  = one; rin[1]  = wide_t'(x.in_x1);  rin[2]  = wide_t'(x.in_x2);
        rout[0] = one; rout[1] = wide_t'(x.out_x1); rout[2] = wide_t'(x.out_x2);
        for (int k = 0; k < 3; k++) begin
            v[k] = clamp(m[k][0] + qprod(m[k][1], rin[1]) + qprod(m[k][2], rin[2]), clipped);
            w[k] = clamp(m[k][0] + qprod(m[k][1], rout[1]) + qprod(m[k][2], rout[2]),
                         clipped);
        end
        dii = clamp(qprod(rin[0], v[0]) + qprod(rin[1], v[1]) + qprod(rin[2], v[2]), clipped);
        doo = clamp(qprod(rout[0], w[0]) + qprod(rout[1], w[1]) + qprod(rout[2], w[2]),
                    clipped);
        dio = clamp(qprod(rin[0], w[0]) + qprod(rin[1], w[1]) + qprod(rin[2], w[2]), clipped);
        dd  = clamp(qprod(one + dii, one - doo) + qprod(dio, dio) - one, clipped);
        pii = clamp(qprod(v[0], v[0]) + qprod(v[1], v[1]) + qprod(v[2], v[2]), clipped);
        poo = clamp(qprod(w[0], w[0]) + qprod(w[1], w[1]) + qprod(w[2], w[2]), clipped);
        pio = clamp(qprod(v[0], w[0]) + qprod(v[1], w[1]) + qprod(v[2], w[2]), clipped);
        num = clamp(qprod(one - dii, poo) + 2 * qprod(dio, pio) - qprod(one + doo, pii),
                    clipped);
        den = one + dd;
        da  = '0;
        r.div_zero = (den == 0);
        if (den != 0) begin
            da = clamp((num * one) / den, clipped);
        end
        r.delta_d    = dd[31:0];
        r.lev_in     = dii[31:0];
        r.lev_out    = doo[31:0];
        r.cross_form = dio[31:0];
        r.delta_a    = da[31:0];
        r.saturated  = clipped;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // Everything changes at the rising edge, so the falling edge sees the beat
    // that the next rising edge will accept.
    always @(negedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                exp_deltas.push_back(exchange_delta(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (exp_deltas.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, i_out_data);
                end else begin
                    want = exp_deltas.pop_front();
                    check_field("delta_d", want.delta_d, i_out_data.delta_d);
                    check_field("lev_in", want.lev_in, i_out_data.lev_in);
                    check_field("lev_out", want.lev_out, i_out_data.lev_out);
                    check_field("cross_form", want.cross_form, i_out_data.cross_form);
                    check_field("delta_a", want.delta_a, i_out_data.delta_a);
                    check_field("div_zero", 32'(want.div_zero), 32'(i_out_data.div_zero));
                    check_field("saturated", 32'(want.saturated), 32'(i_out_data.saturated));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_fedorov_exchange_delta_core.sv =====
module tb_fedorov_exchange_delta_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fed_pkg::t_in;
    import fed_pkg::t_out;

    localparam int          RAND_ITEMS = 1400;
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_out  o_out_data;
    int    fail_count;
    int    pending;
    int    stall_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    fedorov_exchange_delta_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    fed_delta_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 40);
        end
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    endfunction

    // Output backpressure: runs of ready and stall, mostly short.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 2) != 0);
            stall_left  <= gap_len();
        end
    end

    // Valid stays high into the next beat when there is no gap.
    task automatic send_beat(input t_in beat);
        int   gap;
        logic taken;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3:       return $urandom_range(0, 3) == 0 ? 32'h7fffffff :
                            ($urandom_range(0, 1) ? 32'h80000000 : Q_ONE);
            default: return $urandom_range(0, 32'h0003ffff) - 32'h0002_0000;
        endcase
    endfunction

    function automatic t_in make_beat(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d,
                                      input logic [31:0] e, input logic [31:0] f,
                                      input logic [31:0] ix1, input logic [31:0] ix2,
                                      input logic [31:0] ox1, input logic [31:0] ox2);
        t_in t;
        t.m00 = a; t.m01 = b; t.m02 = c; t.m11 = d; t.m12 = e; t.m22 = f;
        t.in_x1 = ix1; t.in_x2 = ix2; t.out_x1 = ox1; t.out_x2 = ox2;
        return t;
    endfunction

    initial begin
        t_in beat;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat('0);
        send_beat(make_beat(Q_ONE, 0, 0, Q_ONE, 0, Q_ONE, 0, 0, 0, 0));
        send_beat(make_beat(Q_ONE, 0, 0, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, Q_ONE));
        // A unit m11 with the leaving row at x1 = 1 makes the divisor zero.
        send_beat(make_beat(0, 0, 0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0));
        send_beat(make_beat(0, 0, 0, Q_ONE, 0, 0, 0, 0, -Q_ONE, 0));
        send_beat(make_beat(0, 0, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE));
        send_beat('1);
        send_beat({10{32'h7fffffff}});
        send_beat({10{32'h80000000}});
        send_beat(make_beat(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h80000000));
        send_beat(make_beat(32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                            32'h0010_0000, 32'h0010_0000, 32'hfff0_0000, 32'hfff0_0000));
        send_beat(make_beat(1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        send_beat(make_beat(32'h0000_8000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(Q_ONE, 32'h0000_8000, 32'hffff_8000, Q_ONE, 32'h0000_4000,
                            Q_ONE, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000, 0));

        for (int n = 0; n < RAND_ITEMS; n++) begin
            beat = make_beat(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                             rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
            send_beat(beat);
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
